// ----- design/nmf_pkg.sv -----
package nmf_pkg;

  // Default filter length
  localparam int TAPS_DEF = 64;

  // Field widths
  localparam int SAMPLE_W  = 16;
  localparam int NOISE_W   = 16;
  localparam int TAP_W     = 16;
  localparam int TIDX_W    = 6;
  localparam int SGAIN_W   = 32;
  localparam int NGAIN_W   = 14;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  // Mix in Q.12: the noise product sets the width, the signal term fits inside
  localparam int MIX_W  = NOISE_W + NGAIN_W + 1;
  localparam int PROD_W = MIX_W + TAP_W;

  // Fixed point shifts
  localparam int SIG_SHIFT = 20;  // Q.32 product down to Q.12
  localparam int OUT_SHIFT = 26;  // Q.26 down to integer
  localparam int MIX_ALIGN = 14;  // Q.12 up to Q.26

  // Input word commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TAP    = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EFFECT = 2'd0,
    CFG_FILTER = 2'd1,
    CFG_SGAIN  = 2'd2,
    CFG_NGAIN  = 2'd3
  } cfg_idx_e;

  // Control from the sequencer to the MAC unit
  typedef struct packed {
    logic clear;
    logic vld;
  } mac_ctl_t;

endpackage

// ----- design/nmf_if.sv -----
// Input word: one audio command or one tap load
interface nmf_in_if;
  import nmf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       command;
  logic signed [SAMPLE_W-1:0] audio_in;
  logic signed [NOISE_W-1:0]  noise_in;
  logic [TIDX_W-1:0]          tap_index;
  logic signed [TAP_W-1:0]    tap_value;

  modport source (
    output valid, command, audio_in, noise_in, tap_index, tap_value,
    input  ready
  );

  modport sink (
    input  valid, command, audio_in, noise_in, tap_index, tap_value,
    output ready
  );
endinterface

// Output word: one processed sample
interface nmf_out_if;
  import nmf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] audio_out;
  logic                       clipped;

  modport source (
    output valid, audio_out, clipped,
    input  ready
  );

  modport sink (
    input  valid, audio_out, clipped,
    output ready
  );
endinterface

// ----- design/nmf_vram.sv -----
// Single-port-write, single-port-read RAM with registered read and
// per-entry valid bits; an entry never written reads as zero.
module nmf_vram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rdata_q;

  // valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  // storage write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, masked by the valid bit
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (vld_q[raddr_i]) begin
        rdata_q <= mem[raddr_i];
      end else begin
        rdata_q <= '0;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/nmf_mac.sv -----
// Multiply-accumulate: one line sample times one tap per cycle,
// product registered, then summed.
module nmf_mac #(
  parameter int TAPS = nmf_pkg::TAPS_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  nmf_pkg::mac_ctl_t                              ctl_i,
  input  logic signed [nmf_pkg::MIX_W-1:0]               line_i,
  input  logic signed [nmf_pkg::TAP_W-1:0]               tap_i,
  output logic signed [nmf_pkg::PROD_W+$clog2(TAPS)-1:0] acc_o,
  output logic                                           busy_o
);
  import nmf_pkg::*;

  localparam int ACC_W = PROD_W + $clog2(TAPS);

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_q;

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      prod_q <= line_i * tap_i;
    end
  end

  // accumulator
  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = prod_vld_q;

endmodule

// ----- design/noise_mix_fir_bandpass.sv -----
// A tap word is written at its accepting edge. Throughput: one word in work
// at a time; a tap word every cycle, an audio word only after the last result
// has been loaded into the output register, and with the filter on one tap per
// cycle through the single read port of each RAM.
// Reset: defaults, pointer zero, RAM valid bits clear at once; no clear pass.
module noise_mix_fir_bandpass #(
  parameter int TAPS = nmf_pkg::TAPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  nmf_in_if.sink                          in_i,
  nmf_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [nmf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [nmf_pkg::CFG_W-1:0]       cfg_data_i
);
  import nmf_pkg::*;

  localparam int AW     = $clog2(TAPS);
  localparam int ACC_W  = PROD_W + $clog2(TAPS);
  localparam int RND_W  = ACC_W + 1;
  localparam int Q_W    = RND_W - OUT_SHIFT;
  localparam int SIG_W  = SAMPLE_W + SGAIN_W + 1;
  localparam int IDXC_W = ((TIDX_W > AW) ? TIDX_W : AW) + 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_SUM   = 6'b000100,
    S_MAC   = 6'b001000,
    S_DRAIN = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic               eff_q, filt_q;
  logic [SGAIN_W-1:0] sgain_q;
  logic [NGAIN_W-1:0] ngain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_q   <= 1'b1;
      filt_q  <= 1'b1;
      sgain_q <= SGAIN_W'(32'h8000_0000);
      ngain_q <= {NGAIN_W{1'b1}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_EFFECT: eff_q   <= cfg_data_i[0];
        CFG_FILTER: filt_q  <= cfg_data_i[0];
        CFG_SGAIN:  sgain_q <= cfg_data_i[SGAIN_W-1:0];
        CFG_NGAIN:  ngain_q <= cfg_data_i[NGAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // input handshake and tap load decode
  logic              in_acc;
  logic              in_audio;
  logic [IDXC_W-1:0] tidx_ext;
  logic              tap_we;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_audio   = in_acc && (in_i.command == CMD_SAMPLE);
  assign tidx_ext   = IDXC_W'(in_i.tap_index);
  assign tap_we     = in_acc && (in_i.command == CMD_TAP) && (tidx_ext < IDXC_W'(TAPS));

  // sequencer counters and flags
  logic [AW-1:0] wp_q, wp_d, rd_ptr_q, rd_ptr_d, cnt_q, cnt_d, wp_next;
  logic          issue_q, issue_d;
  logic          mac_busy;
  logic          out_load;
  logic          out_vld_q;

  assign wp_next = (wp_q == AW'(TAPS - 1)) ? '0 : wp_q + 1'b1;

  always_comb begin
    state_d  = state_q;
    wp_d     = wp_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    issue_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_audio) begin
          state_d = eff_q ? S_MUL : S_FIN;
        end
      end
      S_MUL: state_d = S_SUM;
      S_SUM: begin
        if (filt_q) begin
          wp_d     = wp_next;
          rd_ptr_d = wp_next;
          cnt_d    = '0;
          state_d  = S_MAC;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MAC: begin
        issue_d  = 1'b1;
        rd_ptr_d = (rd_ptr_q == AW'(TAPS - 1)) ? '0 : rd_ptr_q + 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == AW'(TAPS - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!issue_q && !mac_busy) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wp_q     <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      issue_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      wp_q     <= wp_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      issue_q  <= issue_d;
    end
  end

  // latched sample word
  logic signed [SAMPLE_W-1:0] audio_q;
  logic signed [NOISE_W-1:0]  noise_q;
  logic                       pass_q, fir_q;

  always_ff @(posedge clk_i) begin
    if (in_audio) begin
      audio_q <= in_i.audio_in;
      noise_q <= in_i.noise_in;
      pass_q  <= !eff_q;
      fir_q   <= filt_q;
    end
  end

  // gain multiplies, registered
  logic signed [SIG_W-1:0] sig_q;
  logic signed [MIX_W-1:0] nz_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      sig_q <= audio_q * $signed({1'b0, sgain_q});
      nz_q  <= noise_q * $signed({1'b0, ngain_q});
    end
  end

  // signal term rounded half up to Q.12, plus noise term
  logic signed [SIG_W-1:0] sig_add, sig_sh;
  logic signed [MIX_W-1:0] mix_d, mix_q;

  assign sig_add = sig_q + $signed(SIG_W'(1) << (SIG_SHIFT - 1));
  assign sig_sh  = sig_add >>> SIG_SHIFT;
  assign mix_d   = $signed(sig_sh[MIX_W-1:0]) + nz_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_SUM) begin
      mix_q <= mix_d;
    end
  end

  // delay line and tap RAMs
  logic [MIX_W-1:0] line_rd;
  logic [TAP_W-1:0] tap_rd;

  nmf_vram #(
    .DEPTH (TAPS),
    .WIDTH (MIX_W)
  ) u_line (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    ((state_q == S_SUM) && filt_q),
    .waddr_i (wp_q),
    .wdata_i (mix_d),
    .re_i    (state_q == S_MAC),
    .raddr_i (rd_ptr_q),
    .rdata_o (line_rd)
  );

  nmf_vram #(
    .DEPTH (TAPS),
    .WIDTH (TAP_W)
  ) u_taps (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (tap_we),
    .waddr_i (tidx_ext[AW-1:0]),
    .wdata_i (in_i.tap_value),
    .re_i    (state_q == S_MAC),
    .raddr_i (cnt_q),
    .rdata_o (tap_rd)
  );

  // dot product
  mac_ctl_t                mac_ctl;
  logic signed [ACC_W-1:0] acc;

  assign mac_ctl.clear = (state_q == S_SUM);
  assign mac_ctl.vld   = issue_q;

  nmf_mac #(
    .TAPS (TAPS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .line_i ($signed(line_rd)),
    .tap_i  ($signed(tap_rd)),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

  // round half up from Q.26 (mix aligned first) and saturate, or pass through
  localparam logic signed [Q_W-1:0] QMAX = Q_W'(32767);
  localparam logic signed [Q_W-1:0] QMIN = -Q_W'(32768);

  logic signed [RND_W-1:0]    pre, rnd;
  logic signed [Q_W-1:0]      q;
  logic signed [SAMPLE_W-1:0] y;
  logic                       clip;

  always_comb begin
    if (fir_q) begin
      pre = {acc[ACC_W-1], acc};
    end else begin
      pre = {{(RND_W - MIX_W){mix_q[MIX_W-1]}}, mix_q} <<< MIX_ALIGN;
    end
    rnd = pre + $signed(RND_W'(1) << (OUT_SHIFT - 1));
    q   = $signed(rnd[RND_W-1:OUT_SHIFT]);
    if (pass_q) begin
      y    = audio_q;
      clip = 1'b0;
    end else if (q > QMAX) begin
      y    = 16'sh7FFF;
      clip = 1'b1;
    end else if (q < QMIN) begin
      y    = -16'sh8000;
      clip = 1'b1;
    end else begin
      y    = q[SAMPLE_W-1:0];
      clip = 1'b0;
    end
  end

  // output register
  logic signed [SAMPLE_W-1:0] out_audio_q;
  logic                       out_clip_q;

  assign out_load = (state_q == S_FIN) && (!out_vld_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_audio_q <= y;
      out_clip_q  <= clip;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.audio_out = out_audio_q;
  assign out_o.clipped   = out_clip_q;

endmodule

// ----- design/nmf_check.sv -----
// Port-level checks for the noise mixer
module nmf_check (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           in_command_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [nmf_pkg::SAMPLE_W-1:0]   out_audio_i
);
  import nmf_pkg::*;

  logic       in_acc, out_acc;
  logic       in_audio, in_tap;
  logic [1:0] pend_q;

  assign in_acc   = in_valid_i && in_ready_i;
  assign out_acc  = out_valid_i && out_ready_i;
  assign in_audio = in_acc && (in_command_i == CMD_SAMPLE);
  assign in_tap   = in_acc && (in_command_i == CMD_TAP);

  // audio words accepted and not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_audio ? 1 : 0)
                       - 2'(out_acc ? 1 : 0);
    end
  end

  // a result waits, unchanged, until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_audio_i))
    else $error("output word dropped or changed while stalled");

  // no result without a pending audio word
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != 2'd0)
    else $error("result without an audio word");

  // at most one word in work and one waiting at the output
  a_pend_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 |-> !in_ready_i)
    else $error("input taken with output and datapath both full");

  // a tap load keeps the input open, an audio word closes it
  a_tap_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_tap |=> in_ready_i)
    else $error("tap load stalled the input");

  a_audio_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_audio |=> !in_ready_i)
    else $error("input open while an audio word is in work");

endmodule

bind noise_mix_fir_bandpass nmf_check u_nmf_check (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_command_i (in_i.command),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_audio_i  (out_o.audio_out)
);

// ----- test/noise_mix_fir_bandpass_checker.sv -----
// Watches the input, output and register ports of the noise mixer, predicts
// each output word and compares it with what the block delivers.
module noise_mix_fir_bandpass_checker #(
  parameter int TAPS = nmf_pkg::TAPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  nmf_in_if                             in_w,
  nmf_out_if                            out_w,
  input  logic                          cfg_we_i,
  input  logic [nmf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [nmf_pkg::CFG_W-1:0]     cfg_data_i,
  output int                            err_count_o,
  output int                            pending_o
);
  import nmf_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] audio;
    logic                       clipped;
  } sample_out_t;

  // Shadow copy of the registers and the filter state
  logic                    effect_on;
  logic                    filter_on;
  logic [SGAIN_W-1:0]      sig_gain;
  logic [NGAIN_W-1:0]      noise_gain;
  int                      line_mem [TAPS];
  int                      wr_ptr;
  logic signed [TAP_W-1:0] coef_mem [TAPS];

  sample_out_t expected_out [$];
  int          mismatches = 0;

  assign err_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Round half up at bit sh, then clamp to signed 16 bits
  function automatic sample_out_t round_sat(input longint v, input int sh);
    longint      r;
    sample_out_t o;
    r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
    o.clipped = 1'b0;
    if (r > 32767) begin
      r = 32767;
      o.clipped = 1'b1;
    end else if (r < -32768) begin
      r = -32768;
      o.clipped = 1'b1;
    end
    o.audio = r[SAMPLE_W-1:0];
    return o;
  endfunction

  // Update state for one input word; queue the output it causes, if any
  task automatic predict_word(input logic cmd, input logic signed [SAMPLE_W-1:0] audio,
                              input logic signed [NOISE_W-1:0] noise,
                              input logic [TIDX_W-1:0] idx,
                              input logic signed [TAP_W-1:0] coef);
    longint      mix;
    longint      acc;
    int          k;
    sample_out_t o;
    if (cmd == CMD_TAP) begin
      if (idx < TAPS) coef_mem[idx] = coef;
    end else begin
      if (!effect_on) begin
        o.audio   = audio;
        o.clipped = 1'b0;
      end else begin
        // signal term rounded from Q.32 to Q.12, noise term exact in Q.12
        mix = ((longint'(audio) * longint'({1'b0, sig_gain})
                + (longint'(1) <<< (SIG_SHIFT - 1))) >>> SIG_SHIFT)
              + longint'({1'b0, noise_gain}) * longint'(noise);
        if (!filter_on) begin
          o = round_sat(mix, OUT_SHIFT - MIX_ALIGN);
        end else begin
          line_mem[wr_ptr] = int'(mix);
          wr_ptr = (wr_ptr + 1) % TAPS;
          // oldest sample meets tap 0
          acc = 0;
          for (k = 0; k < TAPS; k++) begin
            acc += longint'(line_mem[(wr_ptr + k) % TAPS]) * longint'(coef_mem[k]);
          end
          o = round_sat(acc, OUT_SHIFT);
        end
      end
      expected_out.push_back(o);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sample_out_t want;
    if (!rst_ni) begin
      effect_on  = 1'b1;
      filter_on  = 1'b1;
      sig_gain   = 32'h8000_0000;
      noise_gain = '1;
      wr_ptr     = 0;
      for (int k = 0; k < TAPS; k++) begin
        line_mem[k] = 0;
        coef_mem[k] = '0;
      end
      expected_out.delete();
    end else begin
      // output side first: it belongs to an older input word
      if (out_w.valid && out_w.ready) begin
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("output word %0d/%0b with nothing expected",
                                    out_w.audio_out, out_w.clipped));
        end else begin
          want = expected_out.pop_front();
          if (out_w.audio_out !== want.audio)
            report_mismatch($sformatf("audio_out %0d, expected %0d",
                                      out_w.audio_out, want.audio));
          if (out_w.clipped !== want.clipped)
            report_mismatch($sformatf("clipped %b, expected %b (audio_out %0d)",
                                      out_w.clipped, want.clipped, want.audio));
        end
      end
      if (in_w.valid && in_w.ready)
        predict_word(in_w.command, in_w.audio_in, in_w.noise_in, in_w.tap_index,
                     in_w.tap_value);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_EFFECT: effect_on  = cfg_data_i[0];
          CFG_FILTER: filter_on  = cfg_data_i[0];
          CFG_SGAIN:  sig_gain   = cfg_data_i[SGAIN_W-1:0];
          CFG_NGAIN:  noise_gain = cfg_data_i[NGAIN_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o = expected_out.size();
  end

endmodule

// ----- test/noise_mix_fir_bandpass_test.sv -----
module noise_mix_fir_bandpass_test;
  import nmf_pkg::*;

  localparam int   HOLD_CYCLES  = 300;
  localparam int   DRAIN_CYCLES = 80;
  localparam int   STALL_LIMIT  = 3000;
  localparam int   TAP_PCT      = 12;

  logic                 clk_i    = 1'b0;
  logic                 rst_ni   = 1'b0;
  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_reqs    = 0;
  int quiet_cycles = 0;
  int err_count;
  int pending;

  nmf_in_if  in_w ();
  nmf_out_if out_w ();

  noise_mix_fir_bandpass uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_w),
    .out_o      (out_w),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  noise_mix_fir_bandpass_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_w        (in_w),
    .out_w       (out_w),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    int served;
    int pct;
    hold_left = 0;
    served    = 0;
    pct       = 0;
    out_w.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      pct = rx_stall_pct;
      if (hold_reqs != served) begin
        served    = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_w.ready <= 1'b0;
        hold_left--;
      end else begin
        out_w.ready <= ($urandom_range(99) >= pct);
      end
    end
  end

  // Watchdog: cycles in a row with no word moved and no register write
  always @(posedge clk_i) begin
    if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Values of random width from 1 to 16 bits, sometimes the extremes
  function automatic logic signed [15:0] rand_val();
    int bits;
    int r;
    if ($urandom_range(15) == 0) return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    bits = $urandom_range(16, 1);
    r = $urandom;
    r = (r <<< (32 - bits)) >>> (32 - bits);
    return r[15:0];
  endfunction

  // Offer one word after a random gap; return at the falling edge after it is taken
  task automatic send_word(input logic cmd, input logic signed [15:0] audio,
                           input logic signed [15:0] noise, input logic [5:0] idx,
                           input logic signed [15:0] coef);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_w.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_w.valid     <= 1'b1;
    in_w.command   <= cmd;
    in_w.audio_in  <= audio;
    in_w.noise_in  <= noise;
    in_w.tap_index <= idx;
    in_w.tap_value <= coef;
    do @(posedge clk_i); while (!in_w.ready);
    @(negedge clk_i);
  endtask

  task automatic play(input logic signed [15:0] audio, input logic signed [15:0] noise);
    send_word(CMD_SAMPLE, audio, noise, 6'($urandom), rand_val());
  endtask

  task automatic load_tap(input logic [5:0] idx, input logic signed [15:0] coef);
    send_word(CMD_TAP, rand_val(), rand_val(), idx, coef);
  endtask

  // Stop offering, wait for every expected word, then let the pipeline settle
  task automatic drain();
    in_w.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_config(input logic effect, input logic filter,
                            input logic [SGAIN_W-1:0] sgain,
                            input logic [NGAIN_W-1:0] ngain);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_EFFECT;
    cfg_data <= CFG_W'(effect);
    @(negedge clk_i);
    cfg_idx  <= CFG_FILTER;
    cfg_data <= CFG_W'(filter);
    @(negedge clk_i);
    cfg_idx  <= CFG_SGAIN;
    cfg_data <= CFG_W'(sgain);
    @(negedge clk_i);
    cfg_idx  <= CFG_NGAIN;
    cfg_data <= CFG_W'(ngain);
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic run_phase(input logic effect, input logic filter,
                           input logic [SGAIN_W-1:0] sgain,
                           input logic [NGAIN_W-1:0] ngain,
                           input int tx_pct, input int rx_pct, input int count,
                           input bit squeeze);
    set_config(effect, filter, sgain, ngain);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    if (squeeze) hold_reqs++;
    repeat (count) begin
      if ($urandom_range(99) < TAP_PCT) load_tap(6'($urandom), rand_val());
      else play(rand_val(), rand_val());
    end
  endtask

  initial begin
    in_w.valid     = 1'b0;
    in_w.command   = CMD_SAMPLE;
    in_w.audio_in  = '0;
    in_w.noise_in  = '0;
    in_w.tap_index = '0;
    in_w.tap_value = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Defaults after reset: all taps zero gives silence, then extreme taps
    play(16'sh7FFF, 16'sh7FFF);
    load_tap(6'd0, 16'sh4000);
    load_tap(6'd63, 16'sh8000);
    load_tap(6'd62, 16'sh7FFF);
    play(16'sh8000, 16'sh8000);
    play(16'sh0000, 16'sh0000);
    play(16'sh0001, -16'sh0001);
    play(16'sh7FFF, 16'sh0000);

    // Filter off with the largest gains: clipping both ways
    set_config(1'b1, 1'b0, 32'hFFFF_FFFF, 14'h3FFF);
    play(16'sh7FFF, 16'sh7FFF);
    play(16'sh8000, 16'sh8000);
    play(-16'sh0001, 16'sh0000);
    play(16'sh0000, 16'sh0001);

    // Effect off: samples pass through, tap loads still land
    set_config(1'b0, 1'b1, '0, '0);
    play(16'sh7FFF, 16'sh0005);
    play(16'sh8000, -16'sh0005);
    load_tap(6'd5, -16'sh0001);

    // Zero gains through the filter
    set_config(1'b1, 1'b1, '0, '0);
    play(16'sh04D2, 16'sh0141);

    // Smallest gains: a noise of exactly one half rounds up
    set_config(1'b1, 1'b0, 32'h0000_0001, 14'd1);
    play(16'sh8000, 16'sh8000);
    play(16'sh7FFF, 16'sh0800);

    // Random phases over settings and idle patterns
    run_phase(1'b1, 1'b1, 32'h8000_0000, 14'h3FFF, 0, 0, 250, 1'b0);
    run_phase(1'b1, 1'b1, $urandom, 14'($urandom), 51, 0, 200, 1'b0);
    run_phase(1'b1, 1'b0, $urandom, 14'($urandom), 0, 51, 120, 1'b0);
    run_phase(1'b0, 1'b1, $urandom, 14'($urandom), 7, 7, 80, 1'b0);
    run_phase(1'b1, 1'b1, '0, '0, 7, 7, 100, 1'b0);
    run_phase(1'b1, 1'b1, $urandom, 14'($urandom), 0, 0, 150, 1'b1);
    run_phase(1'b1, 1'b1, $urandom, 14'($urandom), 0, 51, 250, 1'b0);
    run_phase(1'b1, 1'b0, 32'hFFFF_FFFF, 14'h3FFF, 51, 0, 100, 1'b0);

    drain();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/nmf_pkg.sv
design/nmf_if.sv
design/nmf_vram.sv
design/nmf_mac.sv
design/noise_mix_fir_bandpass.sv
design/nmf_check.sv
test/noise_mix_fir_bandpass_checker.sv
test/noise_mix_fir_bandpass_test.sv
